[sv/led_matrix_frame_scan_macros.svh]
// Assertion macros for the LED matrix frame scan block.
// Used by led_matrix_frame_scan.sv; expects aclk and aresetn in scope.
`ifndef LED_MATRIX_FRAME_SCAN_MACROS_SVH
`define LED_MATRIX_FRAME_SCAN_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define LMFS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lmfs same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LMFS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lmfs next-cycle check failed");

`else

`define LMFS_ASSERT_NOW(name, ante, cons)
`define LMFS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[sv/lmfs_pkg.sv]
// Shared types, codes and helpers for the LED matrix frame scan block.
// Used by the column unit, the frame store and the top level.
package lmfs_pkg;

    localparam int NUM_COLUMNS = 11;
    localparam int NUM_ROWS    = 5;

    // Column address width and the width of a column count.
    localparam int IDX_W = $clog2(NUM_COLUMNS);
    localparam int CNT_W = $clog2(NUM_COLUMNS + 1);
    localparam int ROW_W = 3;
    localparam int REQ_W = 3;
    localparam int DIV_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef logic [NUM_ROWS-1:0] word_t;

    localparam word_t TOP_BIT  = word_t'(1) << (NUM_ROWS - 1);
    localparam word_t ROW_MASK = '1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_OR     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_HSHIFT = 3'd4;
    localparam logic [REQ_W-1:0] REQ_VSHIFT = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOWDOWN    = 2'd1;

    // Operations of the shared column unit.
    typedef enum logic [2:0] {
        UOP_PASS,
        UOP_ZERO,
        UOP_SETPIX,
        UOP_OR,
        UOP_VSHIFT,
        UOP_KEEP_IF_WRAP
    } uop_t;

    typedef struct packed {
        uop_t             op;
        logic [ROW_W-1:0] row;
        logic             pixel_on;
        word_t            bits;
        logic             direction;
        logic             wrap_around;
    } unit_ctrl_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        word_t            data;
    } store_wr_t;

    // One-hot row select inside a column word; row 0 is the top bit.
    function automatic word_t row_sel(input logic [ROW_W-1:0] row);
        row_sel = TOP_BIT >> row;
    endfunction

endpackage

[sv/lmfs_col_unit.sv]
// Shared column unit: transforms one column word per cycle.
// Depends on lmfs_pkg.
module lmfs_col_unit import lmfs_pkg::*; (
    input  unit_ctrl_t ctrl,
    input  word_t      word_in,
    output word_t      word_out,
    output logic       scan_bit
);

    word_t sel;

    assign sel      = row_sel(ctrl.row);
    assign scan_bit = |(word_in & sel);

    // Column word transform selected by the sequencer.
    always_comb begin
        word_out = word_in;
        unique case (ctrl.op)
            UOP_PASS:   word_out = word_in;
            UOP_ZERO:   word_out = '0;
            UOP_SETPIX: word_out = (word_in & ~sel) | (ctrl.pixel_on ? sel : '0);
            UOP_OR:     word_out = word_in | ctrl.bits;
            UOP_VSHIFT: begin
                if (!ctrl.direction) begin
                    word_out = word_in << 1;
                    if (ctrl.wrap_around) begin
                        word_out[0] = word_in[NUM_ROWS-1];
                    end
                end else begin
                    word_out = word_in >> 1;
                    if (ctrl.wrap_around) begin
                        word_out[NUM_ROWS-1] = word_in[0];
                    end
                end
            end
            UOP_KEEP_IF_WRAP: word_out = ctrl.wrap_around ? word_in : '0;
            default:    word_out = word_in;
        endcase
    end

endmodule

[sv/lmfs_frame_store.sv]
// Frame buffer: one column word per column, one read and one write port.
// Depends on lmfs_pkg.
module lmfs_frame_store import lmfs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] rd_addr,
    output word_t            rd_data,
    input  store_wr_t        wr
);

    word_t frame_reg [NUM_COLUMNS];

    // Addresses past the last column read as a dark column.
    assign rd_data = (32'(rd_addr) < NUM_COLUMNS) ? frame_reg[rd_addr] : '0;

    // Column write; reset darkens the whole frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COLUMNS; i++) begin
                frame_reg[i] <= '0;
            end
        end else if (wr.en && (32'(wr.addr) < NUM_COLUMNS)) begin
            frame_reg[wr.addr] <= wr.data;
        end
    end

endmodule

[sv/led_matrix_frame_scan.sv]
// LED matrix frame scan: a sequencer sweeps the frame one column per cycle
// through a shared column unit. Tick without scan, set pixel, OR column and
// unknown requests go from execute straight to output; clear and shifts sweep
// the columns in use (a left shift adds a tail step), a scanning tick all of
// them. One item at a time; the single frame port sets the sweep length.
// Synchronous active-low reset darkens the frame and clears divider and scan row.
`include "led_matrix_frame_scan_macros.svh"

module led_matrix_frame_scan import lmfs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Request channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_req_type,
    input  logic [3:0]            s_column,
    input  logic [2:0]            s_row,
    input  logic                  s_pixel_on,
    input  logic [4:0]            s_column_bits,
    input  logic                  s_direction,
    input  logic                  s_wrap_around,
    // Result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_scan_valid,
    output logic [4:0]            m_row_lines,
    output logic [10:0]           m_col_lines,
    output logic [4:0]            m_pixel_bits,
    output logic                  m_in_range
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_LOOP = 3'd2;
    localparam logic [2:0] S_TAIL = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cols_reg, cols_next;
    logic [DIV_W-1:0]       slow_reg, slow_next;
    logic [DIV_W-1:0]       div_reg, div_next;
    logic [ROW_W-1:0]       scan_row_reg, scan_row_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    word_t                  carry_reg, carry_next;
    logic [NUM_COLUMNS-1:0] col_acc_reg, col_acc_next;

    logic [REQ_W-1:0]       req_reg, req_next;
    logic [3:0]             col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic                   pix_reg, pix_next;
    word_t                  bits_reg, bits_next;
    logic                   dir_reg, dir_next;
    logic                   wrap_reg, wrap_next;

    logic                   sv_reg, sv_next;
    word_t                  rl_reg, rl_next;
    word_t                  pb_reg, pb_next;
    logic                   ir_reg, ir_next;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_sv_reg, m_sv_next;
    word_t                  m_rl_reg, m_rl_next;
    logic [NUM_COLUMNS-1:0] m_cl_reg, m_cl_next;
    word_t                  m_pb_reg, m_pb_next;
    logic                   m_ir_reg, m_ir_next;

    logic [IDX_W-1:0]       rd_addr;
    word_t                  rd_data;
    store_wr_t              wr;
    unit_ctrl_t             uctl;
    word_t                  unit_in;
    word_t                  unit_out;
    logic                   scan_bit;

    logic [DIV_W-1:0]       div_inc;
    logic                   col_out_of_range;
    logic [CNT_W-1:0]       sweep_len;
    logic                   sweep_last;
    logic [IDX_W-1:0]       last_used;

    lmfs_frame_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    lmfs_col_unit u_unit (
        .ctrl     (uctl),
        .word_in  (unit_in),
        .word_out (unit_out),
        .scan_bit (scan_bit)
    );

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_scan_valid = m_sv_reg;
    assign m_row_lines  = m_rl_reg;
    assign m_col_lines  = m_cl_reg;
    assign m_pixel_bits = m_pb_reg;
    assign m_in_range   = m_ir_reg;

    // Helper values for the sequencer.
    assign div_inc          = div_reg + DIV_W'(1);
    assign col_out_of_range = (8'(col_reg) >= 8'(cols_reg));
    assign sweep_len        = (req_reg == REQ_TICK) ? CNT_W'(NUM_COLUMNS) : cols_reg;
    assign sweep_last       = ((CNT_W'(idx_reg) + CNT_W'(1)) == sweep_len);
    assign last_used        = IDX_W'(cols_reg - CNT_W'(1));

    // Sequencer: one frame access and one pass of the column unit per cycle.
    always_comb begin
        state_next    = state_reg;
        cols_next     = cols_reg;
        slow_next     = slow_reg;
        div_next      = div_reg;
        scan_row_next = scan_row_reg;
        idx_next      = idx_reg;
        carry_next    = carry_reg;
        col_acc_next  = col_acc_reg;
        req_next      = req_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pix_next      = pix_reg;
        bits_next     = bits_reg;
        dir_next      = dir_reg;
        wrap_next     = wrap_reg;
        sv_next       = sv_reg;
        rl_next       = rl_reg;
        pb_next       = pb_reg;
        ir_next       = ir_reg;
        m_valid_next  = m_valid_reg;
        m_sv_next     = m_sv_reg;
        m_rl_next     = m_rl_reg;
        m_cl_next     = m_cl_reg;
        m_pb_next     = m_pb_reg;
        m_ir_next     = m_ir_reg;

        rd_addr          = idx_reg;
        unit_in          = rd_data;
        uctl.op          = UOP_PASS;
        uctl.row         = row_reg;
        uctl.pixel_on    = pix_reg;
        uctl.bits        = bits_reg;
        uctl.direction   = dir_reg;
        uctl.wrap_around = wrap_reg;
        wr.en            = 1'b0;
        wr.addr          = idx_reg;
        wr.data          = unit_out;

        // Configuration writes; out-of-range values are clamped.
        if (cfg_valid) begin
            if (cfg_index == REG_COLS_IN_USE) begin
                cols_next = (cfg_data[3:0] > 4'(NUM_COLUMNS)) ?
                            CNT_W'(NUM_COLUMNS) : CNT_W'(cfg_data[3:0]);
            end else if (cfg_index == REG_SLOWDOWN) begin
                slow_next = (cfg_data == '0) ? DIV_W'(1) : cfg_data;
            end
        end

        // A taken result frees the output register.
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next     = s_req_type;
                    col_next     = s_column;
                    row_next     = s_row;
                    pix_next     = s_pixel_on;
                    bits_next    = s_column_bits;
                    dir_next     = s_direction;
                    wrap_next    = s_wrap_around;
                    sv_next      = 1'b0;
                    rl_next      = ROW_MASK;
                    pb_next      = '0;
                    ir_next      = 1'b1;
                    col_acc_next = '0;
                    idx_next     = '0;
                    state_next   = S_EXEC;
                end
            end

            S_EXEC: begin
                state_next = S_OUT;
                unique case (req_reg)
                    REQ_TICK: begin
                        div_next = div_inc;
                        if (div_inc >= slow_reg) begin
                            div_next      = '0;
                            sv_next       = 1'b1;
                            rl_next       = ~(word_t'(1) << scan_row_reg);
                            row_next      = scan_row_reg;
                            scan_row_next = (32'(scan_row_reg) == NUM_ROWS - 1) ?
                                            '0 : scan_row_reg + ROW_W'(1);
                            state_next    = S_LOOP;
                        end
                    end
                    REQ_CLEAR: begin
                        if (cols_reg != '0) begin
                            state_next = S_LOOP;
                        end
                    end
                    REQ_SET, REQ_OR: begin
                        rd_addr = IDX_W'(col_reg);
                        wr.addr = IDX_W'(col_reg);
                        uctl.op = (req_reg == REQ_SET) ? UOP_SETPIX : UOP_OR;
                        if (col_out_of_range) begin
                            ir_next = 1'b0;
                        end else if (req_reg == REQ_OR) begin
                            wr.en = 1'b1;
                        end else if (32'(row_reg) < NUM_ROWS) begin
                            wr.en   = 1'b1;
                            pb_next = pix_reg ? row_sel(row_reg) : '0;
                        end
                    end
                    REQ_HSHIFT: begin
                        if (cols_reg != '0) begin
                            // Right shift starts from the last used column.
                            if (dir_reg) begin
                                rd_addr    = last_used;
                                uctl.op    = UOP_KEEP_IF_WRAP;
                                carry_next = unit_out;
                            end
                            state_next = S_LOOP;
                        end
                    end
                    REQ_VSHIFT: begin
                        if (cols_reg != '0) begin
                            state_next = S_LOOP;
                        end
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_LOOP: begin
                unique case (req_reg)
                    REQ_TICK: begin
                        col_acc_next[idx_reg] = scan_bit;
                    end
                    REQ_CLEAR: begin
                        uctl.op = UOP_ZERO;
                        wr.en   = 1'b1;
                    end
                    REQ_HSHIFT: begin
                        if (!dir_reg) begin
                            // Left: each column moves one place down.
                            if (idx_reg == '0) begin
                                carry_next = rd_data;
                            end else begin
                                wr.en   = 1'b1;
                                wr.addr = idx_reg - IDX_W'(1);
                            end
                        end else begin
                            // Right: write the carried column, keep this one.
                            unit_in    = carry_reg;
                            wr.en      = 1'b1;
                            carry_next = rd_data;
                        end
                    end
                    REQ_VSHIFT: begin
                        uctl.op = UOP_VSHIFT;
                        wr.en   = 1'b1;
                    end
                    default: begin
                        wr.en = 1'b0;
                    end
                endcase
                if (sweep_last) begin
                    state_next = (req_reg == REQ_HSHIFT && !dir_reg) ? S_TAIL : S_OUT;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_TAIL: begin
                // Left shift end: old first column or dark into the last one.
                unit_in    = carry_reg;
                uctl.op    = UOP_KEEP_IF_WRAP;
                wr.en      = 1'b1;
                wr.addr    = last_used;
                state_next = S_OUT;
            end

            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sv_next    = sv_reg;
                    m_rl_next    = rl_reg;
                    m_cl_next    = col_acc_reg;
                    m_pb_next    = pb_reg;
                    m_ir_next    = ir_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cols_reg     <= CNT_W'(NUM_COLUMNS);
            slow_reg     <= DIV_W'(1);
            div_reg      <= '0;
            scan_row_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cols_reg     <= cols_next;
            slow_reg     <= slow_next;
            div_reg      <= div_next;
            scan_row_reg <= scan_row_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        carry_reg   <= carry_next;
        col_acc_reg <= col_acc_next;
        req_reg     <= req_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        pix_reg     <= pix_next;
        bits_reg    <= bits_next;
        dir_reg     <= dir_next;
        wrap_reg    <= wrap_next;
        sv_reg      <= sv_next;
        rl_reg      <= rl_next;
        pb_reg      <= pb_next;
        ir_reg      <= ir_next;
        m_sv_reg    <= m_sv_next;
        m_rl_reg    <= m_rl_next;
        m_cl_reg    <= m_cl_next;
        m_pb_reg    <= m_pb_next;
        m_ir_reg    <= m_ir_next;
    end

    // A scanning result drives exactly one row low.
    `LMFS_ASSERT_NOW(a_one_row_low, m_valid_reg && m_sv_reg, $countones(~m_rl_reg) == 1)
    // A result without a scan leaves rows and columns dark.
    `LMFS_ASSERT_NOW(a_idle_dark, m_valid_reg && !m_sv_reg, m_rl_reg == ROW_MASK && m_cl_reg == '0)
    // The scan row and the column count stay inside the frame.
    `LMFS_ASSERT_NOW(a_bounds, 1'b1, 32'(scan_row_reg) < NUM_ROWS && 32'(cols_reg) <= NUM_COLUMNS)
    // An accepted request keeps the block busy in the next cycle.
    `LMFS_ASSERT_NEXT(a_busy_after_transfer, s_valid && s_ready, !s_ready)

endmodule

[dv/lmfs_drive_checker.sv]
`timescale 1ns / 100ps
// Checker for the LED matrix frame scan block: it mirrors the frame, divider and scan row,
// predicts the drive result of every request transfer and compares results in order.
// Depends on lmfs_pkg for widths, request codes and register indexes.
module lmfs_drive_checker import lmfs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [REQ_W-1:0]      s_req_type,
    input  logic [3:0]            s_column,
    input  logic [2:0]            s_row,
    input  logic                  s_pixel_on,
    input  logic [4:0]            s_column_bits,
    input  logic                  s_direction,
    input  logic                  s_wrap_around,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_scan_valid,
    input  logic [4:0]            m_row_lines,
    input  logic [10:0]           m_col_lines,
    input  logic [4:0]            m_pixel_bits,
    input  logic                  m_in_range,
    output int unsigned           mismatch_count,
    output int unsigned           awaited_count
);

    typedef struct packed {
        logic                   scan_valid;
        word_t                  row_lines;
        logic [NUM_COLUMNS-1:0] col_lines;
        word_t                  pixel_bits;
        logic                   in_range;
    } drive_t;

    // Mirrored block state and register settings.
    word_t  frame [NUM_COLUMNS];
    int     tick_count;
    int     scan_row;
    int     cols_used;
    int     ticks_per_row;
    drive_t awaited_drives [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: ERROR %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Applies one request to the mirrored frame and returns the drive it should produce.
    function automatic drive_t apply_request(
        input logic [REQ_W-1:0] req,
        input logic [3:0]       col,
        input logic [2:0]       row,
        input logic             pix,
        input word_t            bits,
        input logic             dir,
        input logic             wrap
    );
        drive_t d;
        word_t  sel;
        word_t  w;
        word_t  saved;
        int     i;
        d = '{scan_valid: 1'b0, row_lines: ROW_MASK, col_lines: '0, pixel_bits: '0,
              in_range: 1'b1};
        case (req)
            REQ_TICK: begin
                // The divider is 8 bits wide and fires once it reaches the slowdown factor.
                tick_count = (tick_count + 1) % 256;
                if (tick_count >= ticks_per_row) begin
                    tick_count = 0;
                    sel = TOP_BIT >> scan_row;
                    d.scan_valid = 1'b1;
                    d.row_lines = ~(word_t'(1) << scan_row);
                    for (i = 0; i < NUM_COLUMNS; i++)
                        d.col_lines[i] = |(frame[i] & sel);
                    scan_row = (scan_row + 1) % NUM_ROWS;
                end
            end
            REQ_CLEAR: begin
                for (i = 0; i < cols_used; i++)
                    frame[i] = '0;
            end
            REQ_SET: begin
                // A row beyond the frame leaves everything as it is.
                if (int'(col) >= cols_used) begin
                    d.in_range = 1'b0;
                end else if (int'(row) < NUM_ROWS) begin
                    sel = TOP_BIT >> row;
                    d.pixel_bits = pix ? sel : '0;
                    frame[col] = (frame[col] & ~sel) | d.pixel_bits;
                end
            end
            REQ_OR: begin
                if (int'(col) >= cols_used)
                    d.in_range = 1'b0;
                else
                    frame[col] = frame[col] | bits;
            end
            REQ_HSHIFT: begin
                // Only the used columns move; the vacated end takes the lost column or zero.
                if (cols_used != 0) begin
                    if (!dir) begin
                        saved = frame[0];
                        for (i = 0; i + 1 < cols_used; i++)
                            frame[i] = frame[i + 1];
                        frame[cols_used - 1] = wrap ? saved : '0;
                    end else begin
                        saved = frame[cols_used - 1];
                        for (i = cols_used - 1; i > 0; i--)
                            frame[i] = frame[i - 1];
                        frame[0] = wrap ? saved : '0;
                    end
                end
            end
            REQ_VSHIFT: begin
                // Up moves toward the top bit, which holds row 0.
                for (i = 0; i < cols_used; i++) begin
                    w = frame[i];
                    if (!dir)
                        frame[i] = {w[NUM_ROWS-2:0], wrap & w[NUM_ROWS-1]};
                    else
                        frame[i] = {wrap & w[0], w[NUM_ROWS-1:1]};
                end
            end
            default: begin
            end
        endcase
        return d;
    endfunction

    // Watch all three channels at each rising edge.
    always @(posedge aclk) begin : watch
        drive_t got;
        drive_t want;
        if (!aresetn) begin
            foreach (frame[k])
                frame[k] = '0;
            tick_count = 0;
            scan_row = 0;
            cols_used = NUM_COLUMNS;
            ticks_per_row = 1;
            awaited_drives.delete();
        end else begin
            // Register write transfer.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_COLS_IN_USE: begin
                        cols_used = int'(cfg_data[3:0]);
                        if (cols_used > NUM_COLUMNS)
                            cols_used = NUM_COLUMNS;
                    end
                    REG_SLOWDOWN: begin
                        ticks_per_row = (cfg_data == '0) ? 1 : int'(cfg_data);
                    end
                    default: begin
                    end
                endcase
            end

            // Request transfer.
            if (s_valid && s_ready)
                awaited_drives.push_back(apply_request(s_req_type, s_column, s_row, s_pixel_on,
                                                       s_column_bits, s_direction,
                                                       s_wrap_around));

            // Result transfer, compared with the oldest prediction.
            if (m_valid && m_ready) begin
                got = '{scan_valid: m_scan_valid, row_lines: m_row_lines,
                        col_lines: m_col_lines, pixel_bits: m_pixel_bits,
                        in_range: m_in_range};
                if (awaited_drives.size() == 0) begin
                    report_mismatch($sformatf("result 0x%0h with no request outstanding", got));
                end else begin
                    want = awaited_drives.pop_front();
                    check_field("scan_valid", got.scan_valid, want.scan_valid);
                    check_field("row_lines", got.row_lines, want.row_lines);
                    check_field("col_lines", got.col_lines, want.col_lines);
                    check_field("pixel_bits", got.pixel_bits, want.pixel_bits);
                    check_field("in_range", got.in_range, want.in_range);
                end
            end
        end
        awaited_count = awaited_drives.size();
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Top of the LED matrix frame scan testbench: clock, reset, register setup and request
// traffic under varying back-pressure. Uses lmfs_pkg and the lmfs_drive_checker module.
module tb import lmfs_pkg::*;;

    localparam int HOLD_CYCLES = 300;

    // Request codes and a register index that the block ignores.
    localparam logic [REQ_W-1:0]     REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0]     REQ_SPARE_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [3:0]       column;
        logic [2:0]       row;
        logic             pixel_on;
        logic [4:0]       column_bits;
        logic             direction;
        logic             wrap_around;
    } request_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_COLS_IN_USE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [REQ_W-1:0]      s_req_type = REQ_TICK;
    logic [3:0]            s_column = '0;
    logic [2:0]            s_row = '0;
    logic                  s_pixel_on = 1'b0;
    logic [4:0]            s_column_bits = '0;
    logic                  s_direction = 1'b0;
    logic                  s_wrap_around = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_scan_valid;
    logic [4:0]            m_row_lines;
    logic [10:0]           m_col_lines;
    logic [4:0]            m_pixel_bits;
    logic                  m_in_range;

    int unsigned mismatches;
    int unsigned awaited;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_asks = 0;

    led_matrix_frame_scan u_top (.*);

    lmfs_drive_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_column      (s_column),
        .s_row         (s_row),
        .s_pixel_on    (s_pixel_on),
        .s_column_bits (s_column_bits),
        .s_direction   (s_direction),
        .s_wrap_around (s_wrap_around),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scan_valid  (m_scan_valid),
        .m_row_lines   (m_row_lines),
        .m_col_lines   (m_col_lines),
        .m_pixel_bits  (m_pixel_bits),
        .m_in_range    (m_in_range),
        .mismatch_count(mismatches),
        .awaited_count (awaited)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off when asked.
    initial begin : result_sink
        int holds_done;
        holds_done = 0;
        forever begin
            @(negedge aclk);
            if (hold_asks != holds_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holds_done++;
            end
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one request and returns at the falling edge after its transfer, valid still high.
    task automatic send_request(input request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_req_type    = r.req_type;
        s_column      = r.column;
        s_row         = r.row;
        s_pixel_on    = r.pixel_on;
        s_column_bits = r.column_bits;
        s_direction   = r.direction;
        s_wrap_around = r.wrap_around;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    // Writes one register and returns at the falling edge after the transfer, valid still high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (awaited != 0)
            @(negedge aclk);
    endtask

    // Random request: mostly in-range columns and rows, with every field bit exercised.
    function automatic request_t random_request(input int cols_now, input int tick_pct);
        request_t r;
        int       roll;
        r.column      = 4'($urandom_range(15));
        r.row         = 3'($urandom_range(7));
        r.pixel_on    = 1'($urandom);
        r.column_bits = 5'($urandom);
        r.direction   = 1'($urandom);
        r.wrap_around = 1'($urandom);
        if (cols_now > 0 && $urandom_range(9) < 8)
            r.column = 4'($urandom_range(cols_now - 1));
        if ($urandom_range(9) < 9)
            r.row = 3'($urandom_range(NUM_ROWS - 1));
        roll = $urandom_range(99);
        if (roll < tick_pct) begin
            r.req_type = REQ_TICK;
        end else begin
            roll = $urandom_range(99);
            if (roll < 3)
                r.req_type = REQ_CLEAR;
            else if (roll < 33)
                r.req_type = REQ_SET;
            else if (roll < 58)
                r.req_type = REQ_OR;
            else if (roll < 76)
                r.req_type = REQ_HSHIFT;
            else if (roll < 94)
                r.req_type = REQ_VSHIFT;
            else if (roll < 97)
                r.req_type = REQ_SPARE_6;
            else
                r.req_type = REQ_SPARE_7;
        end
        return r;
    endfunction

    // One setting of both registers, written while idle, followed by random traffic.
    task automatic run_phase(input logic [7:0] cols_val, input logic [7:0] slow_val,
                             input int tick_pct, input int n_items, input bit hold_off);
        int cols_now;
        wait_drained();
        write_reg(REG_COLS_IN_USE, cols_val);
        write_reg(REG_SLOWDOWN, slow_val);
        cfg_valid = 1'b0;
        cols_now = int'(cols_val[3:0]);
        if (cols_now > NUM_COLUMNS)
            cols_now = NUM_COLUMNS;
        if (hold_off)
            hold_asks++;
        repeat (n_items)
            send_request(random_request(cols_now, tick_pct));
        s_valid = 1'b0;
    endtask

    initial begin : stimulus
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // A write to an unused index must leave the reset settings alone.
        write_reg(REG_SPARE, 8'hFF);
        cfg_valid = 1'b0;

        // Directed requests on the reset settings: field extremes, range checks, shifts.
        send_idle_pct = 24;
        recv_idle_pct = 82;
        send_request('{REQ_SET, 4'd0, 3'd0, 1'b1, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_SET, 4'd10, 3'd4, 1'b1, 5'd31, 1'b1, 1'b1});
        send_request('{REQ_SET, 4'd5, 3'd2, 1'b1, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_SET, 4'd5, 3'd2, 1'b0, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_SET, 4'd3, 3'd5, 1'b1, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_SET, 4'd2, 3'd7, 1'b1, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_SET, 4'd11, 3'd1, 1'b1, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_SET, 4'd15, 3'd0, 1'b1, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_OR, 4'd7, 3'd0, 1'b0, 5'd31, 1'b0, 1'b0});
        send_request('{REQ_OR, 4'd15, 3'd0, 1'b0, 5'd31, 1'b0, 1'b0});
        send_request('{REQ_OR, 4'd0, 3'd0, 1'b0, 5'd1, 1'b0, 1'b0});
        repeat (NUM_ROWS)
            send_request('{REQ_TICK, 4'd0, 3'd0, 1'b0, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_HSHIFT, 4'd0, 3'd0, 1'b0, 5'd0, 1'b0, 1'b1});
        send_request('{REQ_HSHIFT, 4'd0, 3'd0, 1'b0, 5'd0, 1'b1, 1'b1});
        send_request('{REQ_HSHIFT, 4'd0, 3'd0, 1'b0, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_HSHIFT, 4'd0, 3'd0, 1'b0, 5'd0, 1'b1, 1'b0});
        send_request('{REQ_VSHIFT, 4'd0, 3'd0, 1'b0, 5'd0, 1'b0, 1'b1});
        send_request('{REQ_VSHIFT, 4'd0, 3'd0, 1'b0, 5'd0, 1'b1, 1'b1});
        send_request('{REQ_VSHIFT, 4'd0, 3'd0, 1'b0, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_VSHIFT, 4'd0, 3'd0, 1'b0, 5'd0, 1'b1, 1'b0});
        send_request('{REQ_SPARE_6, 4'd15, 3'd7, 1'b1, 5'd31, 1'b1, 1'b1});
        send_request('{REQ_SPARE_7, 4'd1, 3'd1, 1'b1, 5'd31, 1'b0, 1'b1});
        send_request('{REQ_TICK, 4'd0, 3'd0, 1'b0, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_CLEAR, 4'd0, 3'd0, 1'b0, 5'd0, 1'b0, 1'b0});
        send_request('{REQ_TICK, 4'd0, 3'd0, 1'b0, 5'd0, 1'b0, 1'b0});
        s_valid = 1'b0;

        // Sender idles lightly, receiver heavily. Covers one column, a zero written as
        // slowdown, a column count above the frame and the slowest scan rate.
        run_phase(8'd11, 8'd1, 30, 220, 1'b0);
        run_phase(8'd1, 8'd0, 30, 180, 1'b0);
        run_phase(8'd15, 8'd255, 90, 300, 1'b0);

        // Roles swapped; no columns in use, then upper data bits that the block drops.
        send_idle_pct = 82;
        recv_idle_pct = 24;
        run_phase(8'd0, 8'd2, 30, 80, 1'b0);
        run_phase(8'hF6, 8'd3, 30, 220, 1'b0);

        // No idling; the first phase starts with a long receiver hold-off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(8'($urandom_range(11, 1)), 8'($urandom_range(4, 1)), 30, 220, 1'b1);
        run_phase(8'd11, 8'd1, 30, 200, 1'b0);

        // Let the last results arrive, then watch for strays before the verdict.
        wait_drained();
        repeat (40) @(negedge aclk);
        if (mismatches == 0 && awaited == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
